FILE: src/dqb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dqb_pkg;

    // Store geometry
    localparam int DEPTH   = 16;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int WORD_W  = 32;
    localparam int LEVEL_W = 5;
    localparam int KIND_W  = 2;

    typedef logic [PTR_W-1:0]   t_ptr;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [LEVEL_W-1:0] t_level;

    // Operation codes carried on the input tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_BACK  = 2'd1,
        KIND_POP_BACK   = 2'd2
    } t_kind;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic exec;      // apply the accepted request to head, count and store
        logic finish;    // deliver the word read for a pop
        logic load_out;  // load the output register this cycle
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic pop_ok;    // current request is a pop on a non-empty store
    } t_status;

    // (base + offset) mod DEPTH, both operands below DEPTH
    function automatic t_ptr ring_add(input t_ptr base, input t_ptr offset);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= (PTR_W+1)'(DEPTH)) begin
            sum = sum - (PTR_W+1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/dqb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module dqb_datapath (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire dqb_pkg::t_cmd i_cmd,
    input  wire  [1:0]       i_kind,
    input  wire  [31:0]      i_data,
    output dqb_pkg::t_status o_status,
    output logic [31:0]      o_data,
    output logic [4:0]       o_level,
    output logic             o_err
);

    dqb_pkg::t_word  r_mem [dqb_pkg::DEPTH];
    dqb_pkg::t_word  r_rd_data;
    dqb_pkg::t_ptr   r_head;
    dqb_pkg::t_ptr   n_head;
    dqb_pkg::t_cnt   r_count;
    dqb_pkg::t_cnt   n_count;
    dqb_pkg::t_word  r_out_data;
    dqb_pkg::t_level r_out_level;
    logic            r_out_err;

    logic            w_full;
    logic            w_empty;
    logic            w_ok;
    logic            w_wr;
    dqb_pkg::t_ptr   w_wr_addr;
    dqb_pkg::t_ptr   w_head_dec;
    dqb_pkg::t_ptr   w_back_slot;
    dqb_pkg::t_ptr   w_last_slot;
    dqb_pkg::t_cnt   w_count_inc;
    dqb_pkg::t_cnt   w_count_dec;

    // Pointer arithmetic
    assign w_full      = (r_count == dqb_pkg::t_cnt'(dqb_pkg::DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_count_inc = r_count + dqb_pkg::t_cnt'(1);
    assign w_count_dec = r_count - dqb_pkg::t_cnt'(1);
    assign w_head_dec  = (r_head == '0) ? dqb_pkg::t_ptr'(dqb_pkg::DEPTH - 1)
                                        : r_head - dqb_pkg::t_ptr'(1);
    assign w_back_slot = dqb_pkg::ring_add(r_head, r_count[dqb_pkg::PTR_W-1:0]);
    assign w_last_slot = dqb_pkg::ring_add(r_head, w_count_dec[dqb_pkg::PTR_W-1:0]);

    // Operation decode; unused code is an error with no change
    always_comb begin
        w_ok      = 1'b0;
        w_wr      = 1'b0;
        w_wr_addr = w_back_slot;
        n_head    = r_head;
        n_count   = r_count;
        unique case (dqb_pkg::t_kind'(i_kind))
            dqb_pkg::KIND_PUSH_FRONT: begin
                w_ok      = !w_full;
                w_wr      = !w_full;
                w_wr_addr = w_head_dec;
                if (!w_full) begin
                    n_head  = w_head_dec;
                    n_count = w_count_inc;
                end
            end
            dqb_pkg::KIND_PUSH_BACK: begin
                w_ok = !w_full;
                w_wr = !w_full;
                if (!w_full) begin
                    n_count = w_count_inc;
                end
            end
            dqb_pkg::KIND_POP_BACK: begin
                w_ok = !w_empty;
                if (!w_empty) begin
                    n_count = w_count_dec;
                end
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
    end

    assign o_status.pop_ok = (dqb_pkg::t_kind'(i_kind) == dqb_pkg::KIND_POP_BACK) && !w_empty;

    // Head and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Word store: one write port, one registered read port at the last occupied slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_wr) begin
            r_mem[w_wr_addr] <= i_data;
        end
        r_rd_data <= r_mem[w_last_slot];
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (i_cmd.finish) begin
                r_out_data  <= r_rd_data;
                r_out_err   <= 1'b0;
                r_out_level <= dqb_pkg::t_level'(r_count);
            end else begin
                r_out_data  <= '0;
                r_out_err   <= !w_ok;
                r_out_level <= dqb_pkg::t_level'(n_count);
            end
        end
    end

    assign o_data  = r_out_data;
    assign o_level = r_out_level;
    assign o_err   = r_out_err;

endmodule

`default_nettype wire

FILE: src/dqb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dqb_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    input  wire dqb_pkg::t_status i_status,
    output dqb_pkg::t_cmd    o_cmd
);

    dqb_pkg::t_state r_state;
    dqb_pkg::t_state n_state;
    logic            r_out_valid;
    logic            w_accept;

    // Take a request when idle and the result register is empty or frees up this cycle
    assign o_in_ready = (r_state == dqb_pkg::ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dqb_pkg::ST_IDLE: begin
                if (w_accept && i_status.pop_ok) begin
                    n_state = dqb_pkg::ST_READ;
                end
            end
            dqb_pkg::ST_READ: begin
                n_state = dqb_pkg::ST_IDLE;
            end
            default: begin
                n_state = dqb_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            dqb_pkg::ST_IDLE: begin
                o_cmd.exec     = w_accept;
                o_cmd.load_out = w_accept && !i_status.pop_ok;
            end
            dqb_pkg::ST_READ: begin
                o_cmd.finish   = 1'b1;
                o_cmd.load_out = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // State and result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dqb_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    // The read state is always followed by idle in the next cycle
    a_read_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dqb_pkg::ST_READ |=> r_state == dqb_pkg::ST_IDLE)
        else $error("read state held longer than one cycle");

    // A successful pop goes through the read state
    a_pop_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_status.pop_ok |=> r_state == dqb_pkg::ST_READ)
        else $error("pop accepted without store read");

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !o_cmd.load_out)
        else $error("result register overwritten while stalled");

    // No request is taken during a pop read
    a_no_accept_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dqb_pkg::ST_READ |-> !o_in_ready)
        else $error("request taken during pop read");
`endif

endmodule

`default_nettype wire

FILE: src/double_ended_queue_buffer.sv
`timescale 1ns / 1ps
`default_nettype none

// Double-ended buffer of up to 16 signed 32-bit words held in a ring store.
// Input stream: s_axis_tuser selects the operation (push front, push back,
// pop back), s_axis_tdata carries the word to push. Every request gives one
// result on the output stream: m_axis_tuser is the error flag (push when
// full, pop when empty, unused operation code), m_axis_tdata carries the
// popped word (zero otherwise) and the fill level after the operation.
// A push or a failed request has its result registered in the cycle after
// it is taken; a successful pop first goes through the registered read of
// the store. Throughput: one push per cycle while results are taken; a pop
// holds off the next request while the single store read port returns the word.
// Reset empties the buffer (head and count cleared); the store is not
// cleared and needs no clearing pass. The result sits in an output register:
// while the receiver stalls the result holds and new requests are refused
// until it is taken; a request is taken in the same cycle the result leaves.
module double_ended_queue_buffer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [31:0] data_in
    input  wire  [1:0]  s_axis_tuser,   // [1:0] kind
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] data_out, [36:32] fill_level, pad
    output logic [0:0]  m_axis_tuser    // [0] status
);

    dqb_pkg::t_cmd    w_cmd;
    dqb_pkg::t_status w_status;
    logic [31:0]      w_data;
    logic [4:0]       w_level;
    logic             w_err;

    // Sequencing
    dqb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Store, pointers and result register
    dqb_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_kind   (s_axis_tuser),
        .i_data   (s_axis_tdata),
        .o_status (w_status),
        .o_data   (w_data),
        .o_level  (w_level),
        .o_err    (w_err)
    );

    assign m_axis_tdata = {3'b000, w_level, w_data};
    assign m_axis_tuser = w_err;

endmodule

`default_nettype wire
